/* design/lfpr_pkg.sv */
// Shared types and constants for the length-framed packet receiver.
// No dependencies.
`timescale 1ns / 1ps

package lfpr_pkg;

	localparam int BYTE_W     = 8;
	localparam int POS_W      = 5;
	localparam int LEN_W      = 6;
	localparam int CFG_IDX_W  = 2;
	localparam int RESULT_CAP = 32;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_START_MARKER = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_MAX_LENGTH   = 2'd1;

	localparam logic [BYTE_W-1:0] RESET_START_MARKER = 8'hAA;
	localparam logic [LEN_W-1:0]  RESET_MAX_LENGTH   = 6'd32;

	typedef enum logic [3:0] {
		PH_HUNT = 4'b0001,
		PH_LEN  = 4'b0010,
		PH_DATA = 4'b0100,
		PH_SUM  = 4'b1000
	} phase_t;

	// one finished frame handed from the parser to the emitter
	typedef struct packed {
		logic             bank;
		logic [LEN_W-1:0] len;
		logic             ok;
	} cmd_t;

	// emitter has read the last byte of a bank
	typedef struct packed {
		logic en;
		logic bank;
	} rel_t;

endpackage

/* design/length_framed_packet_receiver_top.sv */
// Top level of the length-framed packet receiver.
// Depends on lfpr_pkg, lfpr_front, lfpr_cmdq, lfpr_store, lfpr_back.
`timescale 1ns / 1ps

// Receives one raw byte per push beat and parses frames of the form
// marker, length, payload, checksum (8-bit wrapping sum of the length and
// payload bytes). A good frame comes out as one result beat per payload
// byte with last set on the final one; a bad checksum gives a single
// result beat with sum_ok low, payload_byte and byte_position zero and
// last high. Rate: results leave at one beat per cycle while pop keeps up;
// a byte is taken on any push while full is low. The payload buffer has two
// banks, so a new frame can fill while the previous one drains; full rises
// only when the parser reaches a payload byte while both banks still hold
// frames waiting to be drained, or reaches a checksum byte while the two-entry
// frame descriptor queue is full. On an idle output side the first result of
// a frame goes from its checksum beat through the descriptor queue, one
// buffer read stage and the output register. No clearing pass after reset.
// Length bytes above min(max_length, MAX_PAYLOAD, 32) or equal to zero drop
// the frame and resume the marker hunt; configuration writes
// (cfg_index 0 = start_marker, 1 = max_length) are always accepted.

module length_framed_packet_receiver_top #(
	parameter int MAX_PAYLOAD = 32
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [lfpr_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [lfpr_pkg::BYTE_W-1:0]    cfg_data,
	input  logic                          push,
	output logic                          full,
	input  logic [lfpr_pkg::BYTE_W-1:0]    rx_byte,
	input  logic                          pop,
	output logic                          empty,
	output logic [lfpr_pkg::BYTE_W-1:0]    payload_byte,
	output logic [lfpr_pkg::POS_W-1:0]     byte_position,
	output logic [lfpr_pkg::LEN_W-1:0]     frame_length,
	output logic                          sum_ok,
	output logic                          last
);

	// bytes actually stored per bank
	localparam int DEPTH = (MAX_PAYLOAD < lfpr_pkg::RESULT_CAP) ? MAX_PAYLOAD
	                                                            : lfpr_pkg::RESULT_CAP;
	localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	logic                        wr_en;
	logic [IDX_W:0]              wr_addr;
	logic [lfpr_pkg::BYTE_W-1:0] wr_data;
	logic                        rd_en;
	logic [IDX_W:0]              rd_addr;
	logic [lfpr_pkg::BYTE_W-1:0] rd_data;
	logic                        cmd_push;
	logic                        cmd_pop;
	logic                        cmd_full;
	logic                        cmd_empty;
	lfpr_pkg::cmd_t              cmd_din;
	lfpr_pkg::cmd_t              cmd_dout;
	lfpr_pkg::rel_t              rel;

	// registers are plain flops, a write always lands
	assign cfg_ready = 1'b1;

	lfpr_front #(
		.DEPTH (DEPTH),
		.IDX_W (IDX_W)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.push      (push),
		.rx_byte   (rx_byte),
		.full      (full),
		.wr_en     (wr_en),
		.wr_addr   (wr_addr),
		.wr_data   (wr_data),
		.cmd_push  (cmd_push),
		.cmd_din   (cmd_din),
		.cmd_full  (cmd_full),
		.rel       (rel)
	);

	lfpr_cmdq u_cmdq (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (cmd_push),
		.din    (cmd_din),
		.full   (cmd_full),
		.pop    (cmd_pop),
		.dout   (cmd_dout),
		.empty  (cmd_empty)
	);

	lfpr_store #(
		.IDX_W (IDX_W)
	) u_store (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	lfpr_back #(
		.IDX_W (IDX_W)
	) u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd_dout),
		.cmd_empty     (cmd_empty),
		.cmd_pop       (cmd_pop),
		.rd_en         (rd_en),
		.rd_addr       (rd_addr),
		.rd_data       (rd_data),
		.rel           (rel),
		.pop           (pop),
		.empty         (empty),
		.payload_byte  (payload_byte),
		.byte_position (byte_position),
		.frame_length  (frame_length),
		.sum_ok        (sum_ok),
		.last          (last)
	);

endmodule

/* design/lfpr_store.sv */
// Two-bank payload buffer: one write port (parser), one registered read port (emitter).
// Depends on lfpr_pkg.
`timescale 1ns / 1ps

module lfpr_store #(
	parameter int IDX_W = 5
) (
	input  logic                       clk,
	input  logic                       wr_en,
	input  logic [IDX_W:0]             wr_addr,
	input  logic [lfpr_pkg::BYTE_W-1:0] wr_data,
	input  logic                       rd_en,
	input  logic [IDX_W:0]             rd_addr,
	output logic [lfpr_pkg::BYTE_W-1:0] rd_data
);

	logic [lfpr_pkg::BYTE_W-1:0] mem_q [0:(2**(IDX_W+1))-1];
	logic [lfpr_pkg::BYTE_W-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

/* design/lfpr_cmdq.sv */
// Two-entry queue of finished-frame descriptors between parser and emitter.
// Depends on lfpr_pkg.
`timescale 1ns / 1ps

module lfpr_cmdq (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  lfpr_pkg::cmd_t din,
	output logic           full,
	input  logic           pop,
	output lfpr_pkg::cmd_t dout,
	output logic           empty
);

	lfpr_pkg::cmd_t slot_q [0:1];
	logic           wr_ptr_q;
	logic           rd_ptr_q;
	logic [1:0]     cnt_q;

	assign full  = (cnt_q == 2'd2);
	assign empty = (cnt_q == 2'd0);
	assign dout  = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= din;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 2'd1;
				2'b01:   cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

`ifndef ASSERT_OFF
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> (!full || pop))
		else $error("cmdq push while full");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !empty)
		else $error("cmdq pop while empty");
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q != 2'd3)
		else $error("cmdq count out of range");
`endif

endmodule

/* design/lfpr_front.sv */
// Parser: config registers, marker hunt, length check, payload fill, checksum.
// Depends on lfpr_pkg; writes lfpr_store and pushes lfpr_cmdq.
`timescale 1ns / 1ps

module lfpr_front #(
	parameter int DEPTH = 32,
	parameter int IDX_W = 5
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_valid,
	input  logic [lfpr_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [lfpr_pkg::BYTE_W-1:0]    cfg_data,
	input  logic                          push,
	input  logic [lfpr_pkg::BYTE_W-1:0]    rx_byte,
	output logic                          full,
	output logic                          wr_en,
	output logic [IDX_W:0]                wr_addr,
	output logic [lfpr_pkg::BYTE_W-1:0]    wr_data,
	output logic                          cmd_push,
	output lfpr_pkg::cmd_t                cmd_din,
	input  logic                          cmd_full,
	input  lfpr_pkg::rel_t                rel
);

	localparam logic [lfpr_pkg::LEN_W-1:0] DEPTH_L = lfpr_pkg::LEN_W'(DEPTH);

	logic [lfpr_pkg::BYTE_W-1:0] marker_q;
	logic [lfpr_pkg::LEN_W-1:0]  max_len_q;
	lfpr_pkg::phase_t            phase_q;
	logic [lfpr_pkg::LEN_W-1:0]  exp_len_q;
	logic [lfpr_pkg::LEN_W-1:0]  fill_q;
	logic [lfpr_pkg::BYTE_W-1:0] sum_q;
	logic                        wb_q;
	logic [1:0]                  busy_q;

	logic                        accept;
	logic [lfpr_pkg::LEN_W-1:0]  limit;
	logic                        len_ok;
	logic                        sum_match;
	logic [lfpr_pkg::LEN_W-1:0]  fill_nxt;
	logic [1:0]                  busy_nxt;

	assign full = ((phase_q == lfpr_pkg::PH_DATA) && busy_q[wb_q]) ||
	              ((phase_q == lfpr_pkg::PH_SUM) && cmd_full);
	assign accept = push && !full;

	assign limit     = (max_len_q < DEPTH_L) ? max_len_q : DEPTH_L;
	assign len_ok    = (rx_byte != '0) && (rx_byte <= {2'b00, limit});
	assign sum_match = (rx_byte == sum_q);
	assign fill_nxt  = fill_q + 6'd1;

	assign wr_en   = accept && (phase_q == lfpr_pkg::PH_DATA);
	assign wr_addr = {wb_q, fill_q[IDX_W-1:0]};
	assign wr_data = rx_byte;

	assign cmd_push     = accept && (phase_q == lfpr_pkg::PH_SUM);
	assign cmd_din.bank = wb_q;
	assign cmd_din.len  = exp_len_q;
	assign cmd_din.ok   = sum_match;

	// release from the emitter and claim by a good checksum never hit the same bank
	always_comb begin
		busy_nxt = busy_q;
		if (rel.en) begin
			busy_nxt[rel.bank] = 1'b0;
		end
		if (cmd_push && sum_match) begin
			busy_nxt[wb_q] = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			marker_q  <= lfpr_pkg::RESET_START_MARKER;
			max_len_q <= lfpr_pkg::RESET_MAX_LENGTH;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				lfpr_pkg::CFG_START_MARKER: marker_q  <= cfg_data;
				lfpr_pkg::CFG_MAX_LENGTH:   max_len_q <= cfg_data[lfpr_pkg::LEN_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= lfpr_pkg::PH_HUNT;
			exp_len_q <= '0;
			fill_q    <= '0;
			sum_q     <= '0;
			wb_q      <= 1'b0;
			busy_q    <= 2'b00;
		end else begin
			busy_q <= busy_nxt;
			if (accept) begin
				unique case (phase_q)
					lfpr_pkg::PH_HUNT: begin
						if (rx_byte == marker_q) begin
							sum_q   <= '0;
							phase_q <= lfpr_pkg::PH_LEN;
						end
					end
					lfpr_pkg::PH_LEN: begin
						if (len_ok) begin
							exp_len_q <= rx_byte[lfpr_pkg::LEN_W-1:0];
							fill_q    <= '0;
							sum_q     <= sum_q + rx_byte;
							phase_q   <= lfpr_pkg::PH_DATA;
						end else begin
							phase_q <= lfpr_pkg::PH_HUNT;
						end
					end
					lfpr_pkg::PH_DATA: begin
						sum_q  <= sum_q + rx_byte;
						fill_q <= fill_nxt;
						if (fill_nxt >= exp_len_q) begin
							phase_q <= lfpr_pkg::PH_SUM;
						end
					end
					lfpr_pkg::PH_SUM: begin
						if (sum_match) begin
							wb_q <= ~wb_q;
						end
						phase_q <= lfpr_pkg::PH_HUNT;
					end
					default: phase_q <= lfpr_pkg::PH_HUNT;
				endcase
			end
		end
	end

`ifndef ASSERT_OFF
	a_fill_free_bank: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en |-> !busy_q[wb_q])
		else $error("payload write into a bank still being emitted");
	a_fill_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en |-> (fill_q < exp_len_q))
		else $error("payload fill beyond frame length");
	a_release_held: assert property (@(posedge clk) disable iff (!arst_n)
		rel.en |-> busy_q[rel.bank])
		else $error("release of a bank that is not held");
`endif

endmodule

/* design/lfpr_back.sv */
// Emitter: walks queued frame descriptors, reads payload, holds the result register.
// Depends on lfpr_pkg; reads lfpr_store and pops lfpr_cmdq.
`timescale 1ns / 1ps

module lfpr_back #(
	parameter int IDX_W = 5
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  lfpr_pkg::cmd_t               cmd,
	input  logic                         cmd_empty,
	output logic                         cmd_pop,
	output logic                         rd_en,
	output logic [IDX_W:0]               rd_addr,
	input  logic [lfpr_pkg::BYTE_W-1:0]   rd_data,
	output lfpr_pkg::rel_t               rel,
	input  logic                         pop,
	output logic                         empty,
	output logic [lfpr_pkg::BYTE_W-1:0]   payload_byte,
	output logic [lfpr_pkg::POS_W-1:0]    byte_position,
	output logic [lfpr_pkg::LEN_W-1:0]    frame_length,
	output logic                         sum_ok,
	output logic                         last
);

	logic [lfpr_pkg::POS_W-1:0]  idx_q;

	logic                        valid_s1;
	logic [lfpr_pkg::POS_W-1:0]  pos_s1;
	logic [lfpr_pkg::LEN_W-1:0]  len_s1;
	logic                        ok_s1;
	logic                        last_s1;

	logic                        out_valid_q;
	logic [lfpr_pkg::BYTE_W-1:0] out_byte_q;
	logic [lfpr_pkg::POS_W-1:0]  out_pos_q;
	logic [lfpr_pkg::LEN_W-1:0]  out_len_q;
	logic                        out_ok_q;
	logic                        out_last_q;

	logic                        stall;
	logic                        adv_s1;
	logic                        issue;
	logic                        issue_last;

	assign stall      = out_valid_q && !pop;
	assign adv_s1     = !valid_s1 || !stall;
	assign issue      = adv_s1 && !cmd_empty;
	assign issue_last = !cmd.ok || (({1'b0, idx_q} + 6'd1) == cmd.len);

	assign cmd_pop  = issue && issue_last;
	assign rd_en    = issue && cmd.ok;
	assign rd_addr  = {cmd.bank, idx_q[IDX_W-1:0]};
	assign rel.en   = issue && cmd.ok && issue_last;
	assign rel.bank = cmd.bank;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q       <= '0;
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (issue) begin
				idx_q <= issue_last ? '0 : idx_q + 5'd1;
			end
			if (adv_s1) begin
				valid_s1 <= issue;
			end
			if (!stall) begin
				out_valid_q <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (issue) begin
			pos_s1  <= cmd.ok ? idx_q : '0;
			len_s1  <= cmd.len;
			ok_s1   <= cmd.ok;
			last_s1 <= issue_last;
		end
		if (!stall && valid_s1) begin
			out_byte_q <= ok_s1 ? rd_data : '0;
			out_pos_q  <= pos_s1;
			out_len_q  <= len_s1;
			out_ok_q   <= ok_s1;
			out_last_q <= last_s1;
		end
	end

	assign empty         = !out_valid_q;
	assign payload_byte  = out_byte_q;
	assign byte_position = out_pos_q;
	assign frame_length  = out_len_q;
	assign sum_ok        = out_ok_q;
	assign last          = out_last_q;

`ifndef ASSERT_OFF
	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_pop |-> !cmd_empty)
		else $error("descriptor popped from empty queue");
	a_release_on_read: assert property (@(posedge clk) disable iff (!arst_n)
		rel.en |-> (rd_en && cmd_pop))
		else $error("bank released without reading its last byte");
	a_s1_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && stall) |=> valid_s1)
		else $error("read stage dropped a beat under stall");
	a_idx_in_frame: assert property (@(posedge clk) disable iff (!arst_n)
		(!cmd_empty && cmd.ok) |-> ({1'b0, idx_q} < cmd.len))
		else $error("emit index past frame length");
`endif

endmodule
